/* sv/clue_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clue_pkg: shared constants and a helper for the centre-loss update engine
// Field widths, parameter defaults and the 16-bit saturation helper.
// ----------------------------------------------------------------------------
package clue_pkg;

	localparam int CLUE_CLASS_COUNT = 16;
	localparam int CLUE_FEATURE_DIM = 64;

	localparam int CLUE_LABEL_W = 4;
	localparam int CLUE_INDEX_W = 6;
	localparam int CLUE_VALUE_W = 16;
	localparam int CLUE_LOSS_W  = 40;
	localparam int CLUE_TERM_W  = 32;
	localparam int CLUE_RATE_W  = 16;
	localparam int CLUE_ADDR_MIN_W = 14;

	localparam logic [CLUE_RATE_W-1:0] CLUE_RATE_RESET = 16'h8000;

	function automatic logic signed [CLUE_VALUE_W-1:0] sat16(input logic signed [19:0] v);
		logic signed [CLUE_VALUE_W-1:0] r;
		if (v > 20'sd32767) begin
			r = 16'sh7fff;
		end else if (v < -20'sd32768) begin
			r = 16'sh8000;
		end else begin
			r = v[CLUE_VALUE_W-1:0];
		end
		return r;
	endfunction

endpackage

/* sv/clue_in_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clue_in_if: feature element channel
// Valid/ready channel carrying one feature element and its tags per word.
// ----------------------------------------------------------------------------
interface clue_in_if;
	logic                                    valid;
	logic                                    ready;
	logic [clue_pkg::CLUE_LABEL_W-1:0]       class_label;
	logic [clue_pkg::CLUE_INDEX_W-1:0]       feature_index;
	logic signed [clue_pkg::CLUE_VALUE_W-1:0] feature_value;
	logic                                    last_of_sample;

	modport source (output valid, output class_label, output feature_index,
		output feature_value, output last_of_sample, input ready);
	modport sink (input valid, input class_label, input feature_index,
		input feature_value, input last_of_sample, output ready);
endinterface

/* sv/clue_out_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clue_out_if: gradient and loss channel
// Valid/ready channel carrying one gradient and the sample loss per word.
// ----------------------------------------------------------------------------
interface clue_out_if;
	logic                                    valid;
	logic                                    ready;
	logic signed [clue_pkg::CLUE_VALUE_W-1:0] gradient;
	logic [clue_pkg::CLUE_LOSS_W-1:0]        sample_loss;
	logic                                    loss_valid;

	modport source (output valid, output gradient, output sample_loss,
		output loss_valid, input ready);
	modport sink (input valid, input gradient, input sample_loss,
		input loss_valid, output ready);
endinterface

/* sv/clue_center_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clue_center_mem: class centre store
// Single-port-write, registered-read RAM with a zeroing sweep after reset.
// ----------------------------------------------------------------------------
module clue_center_mem #(
	parameter int DEPTH = clue_pkg::CLUE_CLASS_COUNT * clue_pkg::CLUE_FEATURE_DIM,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	input  logic                                     rd_en,
	input  logic [AW-1:0]                            rd_addr,
	output logic signed [clue_pkg::CLUE_VALUE_W-1:0] rd_data,
	input  logic                                     wr_en,
	input  logic [AW-1:0]                            wr_addr,
	input  logic signed [clue_pkg::CLUE_VALUE_W-1:0] wr_data,
	output logic                                     busy
);

	logic signed [clue_pkg::CLUE_VALUE_W-1:0] mem [DEPTH];
	logic                                     busy_q;
	logic [AW-1:0]                            clr_addr_q;
	logic                                     we;
	logic [AW-1:0]                            waddr;
	logic signed [clue_pkg::CLUE_VALUE_W-1:0] wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign we    = busy_q | wr_en;
	assign waddr = busy_q ? clr_addr_q : wr_addr;
	assign wdata = busy_q ? '0 : wr_data;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign busy = busy_q;

`ifndef NO_ASSERTIONS
	a_no_read_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !rd_en && !wr_en)
		else $error("centre store accessed during zeroing sweep");

	a_sweep_complete: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> $past(clr_addr_q) == AW'(DEPTH - 1))
		else $error("zeroing sweep ended early");
`endif

endmodule

/* sv/clue_loss_acc.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clue_loss_acc: per-sample loss accumulator
// Saturating 40-bit sum of loss terms, emitted and cleared on the last word.
// ----------------------------------------------------------------------------
module clue_loss_acc (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               upd,
	input  logic                               last,
	input  logic [clue_pkg::CLUE_TERM_W-1:0]   term,
	output logic [clue_pkg::CLUE_LOSS_W-1:0]   loss
);

	logic [clue_pkg::CLUE_LOSS_W-1:0] acc_q;
	logic [clue_pkg::CLUE_LOSS_W:0]   sum;
	logic [clue_pkg::CLUE_LOSS_W-1:0] acc_nxt;

	always_comb begin
		sum     = {1'b0, acc_q} + (clue_pkg::CLUE_LOSS_W + 1)'(term);
		acc_nxt = sum[clue_pkg::CLUE_LOSS_W] ? '1 : sum[clue_pkg::CLUE_LOSS_W-1:0];
		loss    = last ? acc_nxt : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (upd) begin
			acc_q <= last ? '0 : acc_nxt;
		end
	end

`ifndef NO_ASSERTIONS
	a_clear_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		upd && last |=> acc_q == '0)
		else $error("loss accumulator not cleared after last word");

	a_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		upd && !last |=> acc_q >= $past(acc_q))
		else $error("loss accumulator decreased within a sample");
`endif

endmodule

/* sv/center_loss_update_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// center_loss_update_engine_unit: centre-loss gradient and centre update
// Reads the class centre, emits the gradient and sample loss, writes back
// the moved centre.
// ----------------------------------------------------------------------------
//  channel   dir  handshake            payload
//  feat      in   valid/ready          class_label, feature_index,
//                                      feature_value, last_of_sample
//  res       out  valid/ready          gradient, sample_loss, loss_valid
//  cfg_*     in   write enable only    center_rate
//
//  One word per cycle while feat.ready is high; the zeroing sweep, a hazard or
//  a stalled result can hold the input. A word passes stage 1, stage 2 and the
//  result register in that order. After reset the centre store is zeroed, with
//  feat.ready low throughout. A word addressing the same centre entry as one
//  still in the two read-modify-write stages waits until that write lands.
//  A stalled result holds the stages behind it only once they are full.
// ----------------------------------------------------------------------------
module center_loss_update_engine_unit #(
	parameter int CLASS_COUNT = clue_pkg::CLUE_CLASS_COUNT,
	parameter int FEATURE_DIM = clue_pkg::CLUE_FEATURE_DIM
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   cfg_we,
	input  logic [clue_pkg::CLUE_RATE_W-1:0]       cfg_wdata,
	clue_in_if.sink                                feat,
	clue_out_if.source                             res
);

	localparam int DEPTH = CLASS_COUNT * FEATURE_DIM;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = (AW > clue_pkg::CLUE_ADDR_MIN_W) ? AW : clue_pkg::CLUE_ADDR_MIN_W;

	logic [clue_pkg::CLUE_RATE_W-1:0] rate_q;

	logic [CW-1:0] addr_full;
	logic [AW-1:0] addr_in;
	logic          inr_in;
	logic          hazard;
	logic          accept;
	logic          busy;

	logic                                     valid_s1, inr_s1, last_s1;
	logic [AW-1:0]                            addr_s1;
	logic signed [clue_pkg::CLUE_VALUE_W-1:0] f_s1;
	logic signed [clue_pkg::CLUE_VALUE_W-1:0] rd_data;
	logic signed [clue_pkg::CLUE_VALUE_W-1:0] c_s1;
	logic signed [16:0]                       d_s1, cmf_s1;
	logic [16:0]                              step_s1;
	logic signed [33:0]                       dsq_s1;
	logic signed [34:0]                       prod_s1;

	logic                                     valid_s2, inr_s2, last_s2;
	logic [AW-1:0]                            addr_s2;
	logic signed [clue_pkg::CLUE_VALUE_W-1:0] c_s2, grad_s2;
	logic [clue_pkg::CLUE_TERM_W-1:0]         term_s2;
	logic signed [33:0]                       prod_s2;
	logic signed [34:0]                       rnd_s2;
	logic signed [17:0]                       corr_s2;
	logic signed [19:0]                       newc_s2;
	logic signed [clue_pkg::CLUE_VALUE_W-1:0] wdata_s2;

	logic                             out_free, s2_free, s1_free, s2_move, s1_move;
	logic [clue_pkg::CLUE_LOSS_W-1:0] loss_s2;

	logic                                     out_valid_q;
	logic signed [clue_pkg::CLUE_VALUE_W-1:0] grad_q;
	logic [clue_pkg::CLUE_LOSS_W-1:0]         loss_q;
	logic                                     lv_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rate_q <= clue_pkg::CLUE_RATE_RESET;
		end else if (cfg_we) begin
			rate_q <= cfg_wdata;
		end
	end

	// address and hazard check
	always_comb begin
		addr_full = CW'(feat.class_label) * CW'(FEATURE_DIM) + CW'(feat.feature_index);
		addr_in   = addr_full[AW-1:0];
		inr_in    = (int'(feat.class_label) < CLASS_COUNT) &&
			(int'(feat.feature_index) < FEATURE_DIM);
		hazard    = inr_in && ((valid_s1 && inr_s1 && addr_s1 == addr_in) ||
			(valid_s2 && inr_s2 && addr_s2 == addr_in));
	end

	assign out_free = !out_valid_q || res.ready;
	assign s2_free  = !valid_s2 || out_free;
	assign s1_free  = !valid_s1 || s2_free;
	assign s2_move  = valid_s2 && out_free;
	assign s1_move  = valid_s1 && s2_free;

	assign feat.ready = s1_free && !busy && !hazard;
	assign accept     = feat.valid && feat.ready;

	clue_center_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept && inr_in),
		.rd_addr (addr_in),
		.rd_data (rd_data),
		.wr_en   (s2_move && inr_s2),
		.wr_addr (addr_s2),
		.wr_data (wdata_s2),
		.busy    (busy)
	);

	// stage 1: centre read data back, differences and products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_move) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			inr_s1  <= inr_in;
			last_s1 <= feat.last_of_sample;
			addr_s1 <= addr_in;
			f_s1    <= feat.feature_value;
		end
	end

	always_comb begin
		c_s1    = inr_s1 ? rd_data : '0;
		d_s1    = 17'(f_s1) - 17'(c_s1);
		cmf_s1  = 17'(c_s1) - 17'(f_s1);
		step_s1 = 17'h10000 - 17'(rate_q);
		dsq_s1  = 34'(d_s1) * 34'(d_s1);
		prod_s1 = $signed({18'd0, step_s1}) * 35'(cmf_s1);
	end

	// stage 2: new centre, loss term
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s1_move) begin
			valid_s2 <= 1'b1;
		end else if (s2_move) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			inr_s2  <= inr_s1;
			last_s2 <= last_s1;
			addr_s2 <= addr_s1;
			c_s2    <= c_s1;
			grad_s2 <= clue_pkg::sat16(20'(d_s1));
			term_s2 <= dsq_s1[32:1];
			prod_s2 <= prod_s1[33:0];
		end
	end

	always_comb begin
		rnd_s2   = 35'(prod_s2) + 35'sd32768;
		corr_s2  = 18'(rnd_s2 >>> 16);
		newc_s2  = 20'(c_s2) - 20'(corr_s2);
		wdata_s2 = clue_pkg::sat16(newc_s2);
	end

	clue_loss_acc u_loss (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (s2_move),
		.last   (last_s2),
		.term   (term_s2),
		.loss   (loss_s2)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s2_move) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_move) begin
			grad_q <= grad_s2;
			loss_q <= loss_s2;
			lv_q   <= last_s2;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.gradient    = grad_q;
	assign res.sample_loss = loss_q;
	assign res.loss_valid  = lv_q;

`ifndef NO_ASSERTIONS
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && valid_s2 && inr_s1 && inr_s2) |-> addr_s1 != addr_s2)
		else $error("two words in flight on one centre entry");

	a_hold_in_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !feat.ready && !valid_s1 && !valid_s2)
		else $error("word taken during zeroing sweep");
`endif

endmodule

/* dv/clue_center_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clue_center_checker: gradient, loss and centre-store scoreboard
// Watches the feature and result channels and the rate register port. It
// keeps its own centre store and loss sum, works out each expected result
// word as a feature word is accepted, and compares every result word field
// by field with the oldest one waiting. Hands back the number of words still
// due and the number of mismatches.
// ----------------------------------------------------------------------------
module clue_center_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [clue_pkg::CLUE_RATE_W-1:0] cfg_wdata,
	clue_in_if                               feat,
	clue_out_if                              res,
	output int                               pending,
	output int                               fails
);

	localparam int DEPTH = clue_pkg::CLUE_CLASS_COUNT * clue_pkg::CLUE_FEATURE_DIM;
	localparam int VW    = clue_pkg::CLUE_VALUE_W;
	localparam int LW    = clue_pkg::CLUE_LOSS_W;
	localparam logic [LW-1:0] LOSS_CEIL = '1;

	typedef struct {
		logic signed [VW-1:0] gradient;
		logic [LW-1:0]        sample_loss;
		logic                 loss_valid;
	} grad_word_t;

	logic signed [VW-1:0]                 centers [DEPTH];
	logic [LW-1:0]                        loss_sum;
	logic [clue_pkg::CLUE_RATE_W-1:0]     alpha;
	grad_word_t                           grad_due [$];
	int                                   n_bad;

	function automatic logic signed [VW-1:0] clamp_q412(input longint v);
		if (v > 32767) begin
			return 16'sh7fff;
		end else if (v < -32768) begin
			return 16'sh8000;
		end
		return v[VW-1:0];
	endfunction

	task automatic flag(input string msg);
		if (n_bad < 100) begin
			$display("%0t clue_center_checker: %s", $time, msg);
		end
		n_bad++;
	endtask

	task automatic absorb_feature(input logic [clue_pkg::CLUE_LABEL_W-1:0] lbl,
		input logic [clue_pkg::CLUE_INDEX_W-1:0] idx, input logic signed [VW-1:0] fval,
		input logic last);
		bit          hit;
		int          addr;
		longint      c;
		longint      f;
		longint      d;
		longint      prod;
		longint      corr;
		logic [32:0] term;
		logic [LW:0] sum;
		grad_word_t  w;

		hit = (int'(lbl) < clue_pkg::CLUE_CLASS_COUNT) &&
			(int'(idx) < clue_pkg::CLUE_FEATURE_DIM);
		addr = int'(lbl) * clue_pkg::CLUE_FEATURE_DIM + int'(idx);
		c = hit ? longint'(centers[addr]) : 0;
		f = fval;
		d = f - c;

		term = 33'((d * d) >> 1);
		sum = {1'b0, loss_sum} + {8'b0, term};
		loss_sum = sum[LW] ? LOSS_CEIL : sum[LW-1:0];

		if (hit) begin
			prod = (65536 - longint'(alpha)) * (c - f);
			corr = (prod + 32768) >>> 16;
			centers[addr] = clamp_q412(c - corr);
		end

		w.gradient = clamp_q412(d);
		w.loss_valid = last;
		w.sample_loss = last ? loss_sum : '0;
		if (last) begin
			loss_sum = '0;
		end
		grad_due.push_back(w);
	endtask

	task automatic check_result();
		grad_word_t w;

		if (grad_due.size() == 0) begin
			flag($sformatf("unexpected word gradient=%0d loss=%0d last=%0b",
				res.gradient, res.sample_loss, res.loss_valid));
			return;
		end
		w = grad_due.pop_front();
		if (res.gradient !== w.gradient) begin
			flag($sformatf("gradient %0d, expected %0d", res.gradient, w.gradient));
		end
		if (res.sample_loss !== w.sample_loss) begin
			flag($sformatf("sample_loss %0d, expected %0d", res.sample_loss, w.sample_loss));
		end
		if (res.loss_valid !== w.loss_valid) begin
			flag($sformatf("loss_valid %0b, expected %0b", res.loss_valid, w.loss_valid));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DEPTH; i++) begin
				centers[i] = '0;
			end
			loss_sum = '0;
			alpha = clue_pkg::CLUE_RATE_RESET;
			grad_due.delete();
			n_bad = 0;
			pending <= 0;
			fails <= 0;
		end else begin
			if (res.valid && res.ready) begin
				check_result();
			end
			if (feat.valid && feat.ready) begin
				absorb_feature(feat.class_label, feat.feature_index, feat.feature_value,
					feat.last_of_sample);
			end
			if (cfg_we) begin
				alpha = cfg_wdata;
			end
			pending <= grad_due.size();
			fails <= n_bad;
		end
	end

endmodule

/* dv/tb_center_loss_update_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_center_loss_update_engine_unit: centre-loss engine testbench
// Drives feature words with random gaps and stalls the result channel in
// random bursts, moves the centre rate through its extremes and random
// values between phases, and pushes one long sample far enough to saturate
// the loss sum. The checker beside the block does all prediction.
// ----------------------------------------------------------------------------
module tb_center_loss_update_engine_unit;

	localparam int LBL_W  = clue_pkg::CLUE_LABEL_W;
	localparam int IDX_W  = clue_pkg::CLUE_INDEX_W;
	localparam int VAL_W  = clue_pkg::CLUE_VALUE_W;
	localparam int RATE_W = clue_pkg::CLUE_RATE_W;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [RATE_W-1:0] cfg_wdata;
	int                pending;
	int                fails;
	int                gap_pct;
	int                stall_pct;

	clue_in_if  feat_ch ();
	clue_out_if res_ch ();

	center_loss_update_engine_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.feat      (feat_ch),
		.res       (res_ch)
	);

	clue_center_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.feat      (feat_ch),
		.res       (res_ch),
		.pending   (pending),
		.fails     (fails)
	);

	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#10_000_000;
		$display("[center_loss_update_engine_unit] ERROR");
		$finish;
	end

	always begin
		@(posedge clk);
		if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
			res_ch.ready <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		res_ch.ready <= 1'b1;
	end

	function automatic int pick_pct();
		case ($urandom_range(0, 3))
			0: return 0;
			1: return 10;
			2: return 30;
			default: return 60;
		endcase
	endfunction

	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 16'sh7fff;
			1: return 16'sh8000;
			2: return 16'($urandom_range(0, 255) - 128);
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic put_word(input logic [LBL_W-1:0] lbl,
		input logic [IDX_W-1:0] idx, input logic signed [VAL_W-1:0] val,
		input logic last);
		feat_ch.valid <= 1'b1;
		feat_ch.class_label <= lbl;
		feat_ch.feature_index <= idx;
		feat_ch.feature_value <= val;
		feat_ch.last_of_sample <= last;
		do @(posedge clk); while (!feat_ch.ready);
		if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
			feat_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	// hold until every word in flight has come back
	task automatic drain();
		feat_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	task automatic write_rate(input logic [RATE_W-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic run_samples(input int count);
		int               done;
		int               len;
		int               mode;
		logic [LBL_W-1:0] lbl;
		logic [IDX_W-1:0] idx;

		done = 0;
		while (done < count) begin
			lbl = LBL_W'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 1) :
				$urandom_range(0, 15));
			case ($urandom_range(0, 7))
				0: len = 64;
				1: len = 1;
				default: len = $urandom_range(2, 8);
			endcase
			mode = $urandom_range(0, 3);
			idx = IDX_W'($urandom);
			for (int k = 0; k < len; k++) begin
				case (mode)
					0: idx = idx + IDX_W'(k != 0);
					1: idx = idx;
					2: idx = IDX_W'($urandom);
					default: idx = IDX_W'($urandom_range(0, 3));
				endcase
				// break the sample now and then
				if ($urandom_range(0, 9) == 0) begin
					lbl = LBL_W'($urandom);
				end
				put_word(lbl, idx, pick_value(), k == len - 1);
				done++;
			end
		end
	endtask

	initial begin
		int plan [7];

		plan = '{65535, 1, -1, 0, -1, 32768, -1};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		feat_ch.valid = 1'b0;
		feat_ch.class_label = '0;
		feat_ch.feature_index = '0;
		feat_ch.feature_value = '0;
		feat_ch.last_of_sample = 1'b0;
		res_ch.ready = 1'b0;
		gap_pct = 0;
		stall_pct = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		put_word(4'd0, 6'd0, 16'sh7fff, 1'b0);
		put_word(4'd0, 6'd0, 16'sh8000, 1'b0);
		put_word(4'd15, 6'd63, 16'sh8000, 1'b0);
		put_word(4'd15, 6'd63, 16'sh7fff, 1'b1);
		put_word(4'd0, 6'd63, 16'sh0000, 1'b1);
		put_word(4'd15, 6'd0, 16'sh0001, 1'b0);
		put_word(4'd15, 6'd0, -16'sh0001, 1'b1);
		put_word(4'd7, 6'd42, 16'sh1000, 1'b0);
		put_word(4'd7, 6'd42, 16'sh1000, 1'b1);

		// full step: the centre jumps to the feature, so the next gradient saturates
		write_rate(16'd0);
		put_word(4'd1, 6'd1, 16'sh8000, 1'b0);
		put_word(4'd1, 6'd1, 16'sh7fff, 1'b1);
		put_word(4'd2, 6'd2, 16'sh7fff, 1'b0);
		put_word(4'd2, 6'd2, 16'sh8000, 1'b1);

		write_rate(16'hffff);
		put_word(4'd3, 6'd3, 16'sh7fff, 1'b0);
		put_word(4'd3, 6'd3, 16'sh7fff, 1'b1);

		// one long sample of extreme swings, enough to saturate the loss sum
		write_rate(16'd0);
		gap_pct = 10;
		stall_pct = 10;
		for (int k = 0; k < 540; k++) begin
			put_word(4'd4, 6'd9, (k % 2 == 0) ? 16'sh7fff : 16'sh8000, k == 539);
		end

		foreach (plan[p]) begin
			write_rate((plan[p] < 0) ? RATE_W'($urandom) : RATE_W'(plan[p]));
			if (p == 6) begin
				gap_pct = 0;
				stall_pct = 0;
			end else begin
				gap_pct = pick_pct();
				stall_pct = pick_pct();
			end
			run_samples(160);
		end

		drain();
		repeat (10) @(posedge clk);
		if (fails == 0) begin
			$display("[center_loss_update_engine_unit] OK");
		end else begin
			$display("[center_loss_update_engine_unit] ERROR");
		end
		$finish;
	end

endmodule
